// ----- rtl/thai_tone_mark_utf8_rewriter_assert.svh -----
// assertion macros shared by the rewriter checker
`ifndef THAI_TONE_MARK_UTF8_REWRITER_ASSERT_SVH
`define THAI_TONE_MARK_UTF8_REWRITER_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define TTMR_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while reset is low
`define TTMR_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/ttmr_pkg.sv -----
// shared types, code point constants and decode helpers for the tone mark rewriter
package ttmr_pkg;

	localparam int TTMR_QUEUE_DEPTH = 4;

	localparam logic [20:0] CP_TONE_FIRST     = 21'h00E48;
	localparam logic [20:0] CP_TONE_LAST      = 21'h00E4C;
	localparam logic [20:0] CP_ALT_TONE_FIRST = 21'h0F70A;
	localparam logic [20:0] CP_ALT_TONE_LAST  = 21'h0F70E;
	localparam logic [20:0] CP_SARA_AM        = 21'h00E33;
	localparam logic [20:0] CP_MAI_HAN_AKAT   = 21'h00E31;
	localparam logic [20:0] CP_SARA_I         = 21'h00E34;
	localparam logic [20:0] CP_SARA_UEE       = 21'h00E37;
	localparam logic [20:0] CP_MAITAIKHU      = 21'h00E47;
	localparam logic [20:0] CP_NIKHAHIT       = 21'h00E4D;
	localparam logic [20:0] CP_THAI_FIRST     = 21'h00E00;
	localparam logic [20:0] CP_THAI_LAST      = 21'h00E7F;
	localparam logic [20:0] CP_ASCII_FIRST    = 21'h00020;
	localparam logic [20:0] CP_ASCII_LAST     = 21'h0007E;
	localparam logic [20:0] CP_NEWLINE        = 21'h0000A;
	localparam logic [20:0] CP_DEGREE         = 21'h000B0;
	localparam logic [20:0] CP_MIDDLE_DOT     = 21'h000B7;
	localparam logic [20:0] CP_EN_DASH        = 21'h02013;
	localparam logic [20:0] CP_EM_DASH        = 21'h02014;
	localparam logic [20:0] CP_ELLIPSIS       = 21'h02026;
	localparam logic [20:0] CP_RIGHT_ARROW    = 21'h02192;

	localparam logic [15:0] TONE_OFFSET = 16'(CP_ALT_TONE_FIRST - CP_TONE_FIRST);

	// one code point on its way from the decoder to the encoder
	typedef struct packed {
		logic [15:0] point;
		logic        last;
		logic        nob;
	} token_t;

	function automatic logic renderable(input logic [20:0] cp);
		renderable = (cp >= CP_ASCII_FIRST && cp <= CP_ASCII_LAST) ||
			(cp >= CP_THAI_FIRST && cp <= CP_THAI_LAST) ||
			(cp >= CP_ALT_TONE_FIRST && cp <= CP_ALT_TONE_LAST) ||
			cp == CP_DEGREE || cp == CP_MIDDLE_DOT || cp == CP_EN_DASH ||
			cp == CP_EM_DASH || cp == CP_ELLIPSIS || cp == CP_RIGHT_ARROW ||
			cp == CP_NEWLINE;
	endfunction

	function automatic logic upper_vowel(input logic [15:0] cp);
		logic [20:0] w;
		w = {5'b0, cp};
		upper_vowel = w == CP_MAI_HAN_AKAT || (w >= CP_SARA_I && w <= CP_SARA_UEE) ||
			w == CP_NIKHAHIT || w == CP_MAITAIKHU;
	endfunction

	// tone mark moves to its raised glyph when asked to
	function automatic logic [15:0] tone_map(input logic [15:0] cp, input logic raise);
		logic [20:0] w;
		w = {5'b0, cp};
		if (raise && w >= CP_TONE_FIRST && w <= CP_TONE_LAST) begin
			tone_map = cp + TONE_OFFSET;
		end else begin
			tone_map = cp;
		end
	endfunction

	function automatic logic [2:0] lead_need(input logic [7:0] b);
		if (b[7] == 1'b0) begin
			lead_need = 3'd1;
		end else if (b[7:5] == 3'b110) begin
			lead_need = 3'd2;
		end else if (b[7:4] == 4'b1110) begin
			lead_need = 3'd3;
		end else if (b[7:3] == 5'b11110) begin
			lead_need = 3'd4;
		end else begin
			lead_need = 3'd1;
		end
	endfunction

	function automatic logic [20:0] assemble(input logic [7:0] b0, input logic [7:0] b1,
		input logic [7:0] b2, input logic [7:0] b3, input logic [2:0] need);
		case (need)
			3'd2: assemble = {10'b0, b0[4:0], b1[5:0]};
			3'd3: assemble = {5'b0, b0[3:0], b1[5:0], b2[5:0]};
			3'd4: assemble = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
			default: assemble = {13'b0, b0};
		endcase
	endfunction

	function automatic logic [1:0] enc_len(input logic [15:0] cp);
		if (cp < 16'h0080) begin
			enc_len = 2'd1;
		end else if (cp < 16'h0800) begin
			enc_len = 2'd2;
		end else begin
			enc_len = 2'd3;
		end
	endfunction

endpackage

// ----- rtl/ttmr_front.sv -----
// front end: utf-8 decode, filtering and tone mark lookahead
module ttmr_front import ttmr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       push_valid,
	output token_t     push_tok,
	input  logic       q_full
);

	typedef enum logic [1:0] {ST_RUN, ST_TAIL, ST_FIN} state_t;

	state_t      state_q;
	logic [7:0]  seq_q [3];
	logic [1:0]  seq_count_q;
	logic [2:0]  seq_need_q;
	logic [15:0] held_q;
	logic        held_valid_q;
	logic        prev_uv_q;
	logic [7:0]  tail_q [4];
	logic [2:0]  tail_n_q;
	logic [2:0]  tail_i_q;
	logic [15:0] pend_q;
	logic        pend_valid_q;

	logic        in_fire;
	logic [2:0]  lead_n;
	logic [20:0] run_cp;
	logic [7:0]  tc0, tc1, tc2, tc3;
	logic [2:0]  tail_need;
	logic        tail_full;
	logic [20:0] tail_cp;
	logic [2:0]  tail_len;
	logic [2:0]  tail_next;
	logic        take_en;
	logic [20:0] take_cp;
	logic [2:0]  take_len;
	logic        take_keep;
	logic [15:0] flush_pt;

	assign in_ready = (state_q == ST_RUN) && !q_full;
	assign in_fire  = in_valid && in_ready;
	assign lead_n   = lead_need(in_byte);

	// completing byte arrives on the input, earlier bytes come from storage
	assign run_cp = assemble(seq_q[0], (seq_need_q == 3'd2) ? in_byte : seq_q[1],
		(seq_need_q == 3'd3) ? in_byte : seq_q[2], in_byte, seq_need_q);

	// re-read of a cut-off sequence, one code point per cycle while the queue is not full
	assign tc0       = tail_q[tail_i_q[1:0]];
	assign tc1       = tail_q[2'(tail_i_q[1:0] + 2'd1)];
	assign tc2       = tail_q[2'(tail_i_q[1:0] + 2'd2)];
	assign tc3       = tail_q[2'(tail_i_q[1:0] + 2'd3)];
	assign tail_need = lead_need(tc0);
	assign tail_full = (tail_need != 3'd1) &&
		(({1'b0, tail_i_q} + {1'b0, tail_need}) <= {1'b0, tail_n_q});
	assign tail_cp   = tail_full ? assemble(tc0, tc1, tc2, tc3, tail_need) : {13'b0, tc0};
	assign tail_len  = tail_full ? tail_need : 3'd1;
	assign tail_next = tail_i_q + tail_len;

	always_comb begin
		take_en  = 1'b0;
		take_cp  = '0;
		take_len = 3'd1;
		case (state_q)
			ST_RUN: begin
				if (in_fire && !in_last) begin
					if (seq_count_q == 2'd0) begin
						if (lead_n == 3'd1) begin
							take_en = 1'b1;
							take_cp = {13'b0, in_byte};
						end
					end else if (({1'b0, seq_count_q} + 3'd1) >= seq_need_q) begin
						take_en  = 1'b1;
						take_cp  = run_cp;
						take_len = seq_need_q;
					end
				end
			end
			ST_TAIL: begin
				if (!q_full) begin
					take_en  = 1'b1;
					take_cp  = tail_cp;
					take_len = tail_len;
				end
			end
			default: ;
		endcase
	end

	assign take_keep = renderable(take_cp);
	assign flush_pt  = tone_map(held_q,
		prev_uv_q || (take_len == 3'd3 && take_cp == CP_SARA_AM));

	always_comb begin
		push_valid = 1'b0;
		push_tok   = '{point: flush_pt, last: 1'b0, nob: 1'b0};
		case (state_q)
			ST_RUN: begin
				push_valid = take_en && held_valid_q;
			end
			ST_TAIL: begin
				// during the final item the newest point waits in pend so it can carry last
				push_valid = take_en && held_valid_q && pend_valid_q;
				push_tok   = '{point: pend_q, last: 1'b0, nob: 1'b0};
			end
			ST_FIN: begin
				if (!q_full) begin
					if (held_valid_q) begin
						push_valid = pend_valid_q;
						push_tok   = '{point: pend_q, last: 1'b0, nob: 1'b0};
					end else begin
						push_valid = 1'b1;
						push_tok   = '{point: pend_q, last: 1'b1, nob: !pend_valid_q};
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_RUN;
			seq_count_q  <= 2'd0;
			held_valid_q <= 1'b0;
			prev_uv_q    <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			if (take_en) begin
				held_valid_q <= take_keep;
				if (held_valid_q) begin
					prev_uv_q <= upper_vowel(held_q);
				end
				if (state_q == ST_TAIL && held_valid_q) begin
					pend_valid_q <= 1'b1;
				end
			end
			case (state_q)
				ST_RUN: begin
					if (in_fire) begin
						if (in_last) begin
							seq_count_q <= 2'd0;
							state_q     <= ST_TAIL;
						end else if (seq_count_q == 2'd0) begin
							if (lead_n != 3'd1) begin
								seq_count_q <= 2'd1;
							end
						end else if (take_en) begin
							seq_count_q <= 2'd0;
						end else begin
							seq_count_q <= seq_count_q + 2'd1;
						end
					end
				end
				ST_TAIL: begin
					if (take_en && tail_next == tail_n_q) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!q_full) begin
						if (held_valid_q) begin
							held_valid_q <= 1'b0;
							pend_valid_q <= 1'b1;
						end else begin
							state_q      <= ST_RUN;
							prev_uv_q    <= 1'b0;
							pend_valid_q <= 1'b0;
						end
					end
				end
				default: state_q <= ST_RUN;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take_en && take_keep) begin
			held_q <= take_cp[15:0];
		end
		if (take_en && state_q == ST_TAIL && held_valid_q) begin
			pend_q <= flush_pt;
		end
		if (state_q == ST_FIN && !q_full && held_valid_q) begin
			pend_q <= flush_pt;
		end
		if (in_fire) begin
			if (in_last) begin
				for (int k = 0; k < 3; k++) begin
					if (k < int'(seq_count_q)) begin
						tail_q[k] <= seq_q[k];
					end else begin
						tail_q[k] <= in_byte;
					end
				end
				tail_q[3] <= in_byte;
				tail_n_q <= {1'b0, seq_count_q} + 3'd1;
				tail_i_q <= 3'd0;
			end else if (seq_count_q == 2'd0) begin
				seq_q[0]   <= in_byte;
				seq_need_q <= lead_n;
			end else if (!take_en) begin
				seq_q[seq_count_q] <= in_byte;
			end
		end
		if (state_q == ST_TAIL && take_en) begin
			tail_i_q <= tail_next;
		end
	end

endmodule

// ----- rtl/ttmr_queue.sv -----
// short token queue between decoder and encoder
module ttmr_queue import ttmr_pkg::*; #(
	parameter int DEPTH = TTMR_QUEUE_DEPTH
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push_valid,
	input  token_t push_tok,
	output logic   full,
	output logic   pop_valid,
	output token_t pop_tok,
	input  logic   pop
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	token_t             mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign full      = count_q == CNT_W'(DEPTH);
	assign pop_valid = count_q != '0;
	assign pop_tok   = mem_q[rd_ptr_q];
	assign do_push   = push_valid && !full;
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_tok;
		end
	end

endmodule

// ----- rtl/ttmr_back.sv -----
// back end: utf-8 encoder feeding the output register
module ttmr_back import ttmr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       pop_valid,
	input  token_t     pop_tok,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       out_last,
	output logic       no_byte
);

	token_t     cur_q;
	logic       cur_valid_q;
	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;
	logic       no_byte_q;

	logic       out_free;
	logic       adv;
	logic       done;
	logic [1:0] nb;
	logic [7:0] enc_byte;

	assign out_free = !out_valid_q || out_ready;
	assign nb       = cur_q.nob ? 2'd1 : enc_len(cur_q.point);
	assign adv      = cur_valid_q && out_free;
	assign done     = adv && (idx_q == nb - 2'd1);
	assign pop      = pop_valid && (!cur_valid_q || done);

	always_comb begin
		enc_byte = 8'h00;
		case (nb)
			2'd1: enc_byte = cur_q.nob ? 8'h00 : cur_q.point[7:0];
			2'd2: begin
				if (idx_q == 2'd0) begin
					enc_byte = {3'b110, cur_q.point[10:6]};
				end else begin
					enc_byte = {2'b10, cur_q.point[5:0]};
				end
			end
			2'd3: begin
				case (idx_q)
					2'd0: enc_byte = {4'b1110, cur_q.point[15:12]};
					2'd1: enc_byte = {2'b10, cur_q.point[11:6]};
					default: enc_byte = {2'b10, cur_q.point[5:0]};
				endcase
			end
			default: enc_byte = 8'h00;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				cur_valid_q <= 1'b1;
			end else if (done) begin
				cur_valid_q <= 1'b0;
			end
			if (out_free) begin
				out_valid_q <= adv;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= pop_tok;
			idx_q <= 2'd0;
		end else if (adv) begin
			idx_q <= idx_q + 2'd1;
		end
		if (adv) begin
			out_byte_q <= enc_byte;
			out_last_q <= cur_q.last && (idx_q == nb - 2'd1);
			no_byte_q  <= cur_q.nob;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;
	assign no_byte   = no_byte_q;

endmodule

// ----- rtl/thai_tone_mark_utf8_rewriter.sv -----
// top level of the thai tone mark utf-8 rewriter
// Usage: feed a UTF-8 string one byte per item on in_valid/in_ready, in_last
// set on its final byte. Rewritten bytes leave on out_valid/out_ready, one
// byte per item; out_last marks the final item of the string, and an item
// with no_byte set only marks the end (out_byte is zero then).
// Throughput: one input byte per cycle while the string runs and the queue has
// room; the encoder sends one output byte per cycle unless out_ready stalls
// it, so a 3-byte Thai code point holds it longer; the token queue absorbs this.
// Path: a code point is held until the next one is decoded (tone mark
// lookahead); its first byte then passes the token queue, then the encoder
// into the output register before it shows on out_valid.
// On the final byte the front re-reads each code point of a cut-off sequence
// (at most four) and then flushes, with in_ready low meanwhile.
// Reset: arst_n clears all control state; the block is ready once reset is
// released, no clearing pass is needed.
// Stall: while out_ready is low the output item holds; the queue fills and
// then in_ready falls, so no item is lost or repeated.
module thai_tone_mark_utf8_rewriter import ttmr_pkg::*; #(
	parameter int QUEUE_DEPTH = TTMR_QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       out_last,
	output logic       no_byte
);

	logic   push_valid;
	token_t push_tok;
	logic   q_full;
	logic   pop_valid;
	token_t pop_tok;
	logic   pop;

	ttmr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.in_last    (in_last),
		.push_valid (push_valid),
		.push_tok   (push_tok),
		.q_full     (q_full)
	);

	ttmr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_tok   (push_tok),
		.full       (q_full),
		.pop_valid  (pop_valid),
		.pop_tok    (pop_tok),
		.pop        (pop)
	);

	ttmr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_tok   (pop_tok),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.out_last  (out_last),
		.no_byte   (no_byte)
	);

endmodule

// ----- rtl/ttmr_checker.sv -----
// port-level checks on the rewriter output, bound to the top level
`include "thai_tone_mark_utf8_rewriter_assert.svh"

module ttmr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       out_last,
	input logic       no_byte
);

	// a stalled item holds
	`TTMR_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(out_last) && $stable(no_byte), "output item changed while stalled")

	// an end marker is always the last item and carries a zero byte
	`TTMR_ASSERT_IMP(a_marker_form, clk, arst_n, out_valid && no_byte, out_last && out_byte == 8'h00, "malformed end marker")

	// only renderable code points are sent, none of them encodes a zero byte
	`TTMR_ASSERT_IMP(a_no_zero, clk, arst_n, out_valid && !no_byte, out_byte != 8'h00, "zero byte sent")

	// a lead byte always has continuation bytes after it
	`TTMR_ASSERT_IMP(a_lead_not_last, clk, arst_n, out_valid && out_byte[7:6] == 2'b11, !out_last, "string ends on a lead byte")

endmodule

bind thai_tone_mark_utf8_rewriter ttmr_checker u_ttmr_checker (.*);

// ----- sim/thai_tone_mark_utf8_rewriter_tb.sv -----
`timescale 1ns / 100ps
// self-checking testbench for the thai tone mark utf-8 rewriter
module thai_tone_mark_utf8_rewriter_tb;

	localparam int CLK_HALF = 10;
	localparam int STALL_LIMIT = 2000;
	localparam int ITEMS_PER_PHASE = 160;
	localparam int REPORT_MAX = 10;
	localparam int LONG_HOLD = 150;
	localparam int TAIL_CYCLES = 20;

	localparam logic [20:0] TONE_LO      = 21'h00E48;
	localparam logic [20:0] TONE_HI      = 21'h00E4C;
	localparam logic [20:0] RAISED_LO    = 21'h0F70A;
	localparam logic [20:0] RAISED_HI    = 21'h0F70E;
	localparam logic [20:0] SARA_AM      = 21'h00E33;
	localparam logic [20:0] MAI_HAN_AKAT = 21'h00E31;
	localparam logic [20:0] SARA_I       = 21'h00E34;
	localparam logic [20:0] SARA_UEE     = 21'h00E37;
	localparam logic [20:0] MAITAIKHU    = 21'h00E47;
	localparam logic [20:0] NIKHAHIT     = 21'h00E4D;
	localparam logic [20:0] THAI_LO      = 21'h00E00;
	localparam logic [20:0] THAI_HI      = 21'h00E7F;
	localparam logic [20:0] KO_KAI       = 21'h00E01;
	localparam logic [20:0] SPACE        = 21'h00020;
	localparam logic [20:0] TILDE        = 21'h0007E;
	localparam logic [20:0] NEWLINE      = 21'h0000A;
	localparam logic [20:0] DEGREE       = 21'h000B0;
	localparam logic [20:0] MIDDLE_DOT   = 21'h000B7;
	localparam logic [20:0] EN_DASH      = 21'h02013;
	localparam logic [20:0] EM_DASH      = 21'h02014;
	localparam logic [20:0] ELLIPSIS     = 21'h02026;
	localparam logic [20:0] RIGHT_ARROW  = 21'h02192;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       nob;
	} out_item_t;

	class rewrite_checker;
		out_item_t   due_bytes[$];
		out_item_t   step_out[$];
		logic [7:0]  frag[3];
		int          frag_count;
		int          frag_need;
		logic [15:0] held_cp;
		bit          held_ok;
		bit          after_upper;
		int          fails;
		int          checked;
		int          raised_marks;
		int          end_markers;
		int          strings_done;

		function new();
			clear();
			fails = 0;
			checked = 0;
			raised_marks = 0;
			end_markers = 0;
			strings_done = 0;
		endfunction

		function void clear();
			frag_count = 0;
			frag_need = 0;
			held_cp = '0;
			held_ok = 1'b0;
			after_upper = 1'b0;
		endfunction

		function bit shown(logic [20:0] cp);
			return (cp >= SPACE && cp <= TILDE) || (cp >= THAI_LO && cp <= THAI_HI) ||
				(cp >= RAISED_LO && cp <= RAISED_HI) || cp == DEGREE ||
				cp == MIDDLE_DOT || cp == EN_DASH || cp == EM_DASH ||
				cp == ELLIPSIS || cp == RIGHT_ARROW || cp == NEWLINE;
		endfunction

		function bit upper(logic [20:0] cp);
			return cp == MAI_HAN_AKAT || (cp >= SARA_I && cp <= SARA_UEE) ||
				cp == MAITAIKHU || cp == NIKHAHIT;
		endfunction

		function int seq_len(logic [7:0] b);
			if (!b[7]) return 1;
			if (b[7:5] == 3'b110) return 2;
			if (b[7:4] == 4'b1110) return 3;
			if (b[7:3] == 5'b11110) return 4;
			return 1;
		endfunction

		function logic [20:0] join_seq(input logic [7:0] s[4], input int at, input int need);
			case (need)
				2: return {10'b0, s[at][4:0], s[at+1][5:0]};
				3: return {5'b0, s[at][3:0], s[at+1][5:0], s[at+2][5:0]};
				4: return {s[at][2:0], s[at+1][5:0], s[at+2][5:0], s[at+3][5:0]};
				default: return {13'b0, s[at]};
			endcase
		endfunction

		function void push_byte(logic [7:0] b);
			step_out.push_back('{data: b, last: 1'b0, nob: 1'b0});
		endfunction

		function void encode_point(logic [15:0] cp);
			if (cp < 16'h0080) begin
				push_byte(cp[7:0]);
			end else if (cp < 16'h0800) begin
				push_byte({3'b110, cp[10:6]});
				push_byte({2'b10, cp[5:0]});
			end else begin
				push_byte({4'b1110, cp[15:12]});
				push_byte({2'b10, cp[11:6]});
				push_byte({2'b10, cp[5:0]});
			end
		endfunction

		// held point leaves once its successor is known
		function void release_held(bit before_am);
			logic [15:0] o;
			if (!held_ok) return;
			o = held_cp;
			if (held_cp >= TONE_LO[15:0] && held_cp <= TONE_HI[15:0] &&
					(after_upper || before_am)) begin
				o = held_cp - TONE_LO[15:0] + RAISED_LO[15:0];
				raised_marks++;
			end
			encode_point(o);
			after_upper = upper({5'b0, held_cp});
			held_ok = 1'b0;
		endfunction

		// only a genuine 3-byte sara am raises the tone mark before it
		function void accept_point(logic [20:0] cp, int len);
			release_held(len == 3 && cp == SARA_AM);
			if (shown(cp)) begin
				held_cp = cp[15:0];
				held_ok = 1'b1;
			end
		endfunction

		function void take_source_byte(logic [7:0] b, logic l);
			logic [7:0] seq[4];
			out_item_t  t;
			int         n;
			int         i;
			int         need;
			step_out.delete();
			for (i = 0; i < frag_count; i++) seq[i] = frag[i];
			seq[frag_count] = b;
			n = frag_count + 1;
			if (!l) begin
				if (frag_count == 0) begin
					need = seq_len(b);
					if (need == 1) begin
						accept_point({13'b0, b}, 1);
					end else begin
						frag[0] = b;
						frag_count = 1;
						frag_need = need;
					end
				end else if (n >= frag_need) begin
					accept_point(join_seq(seq, 0, frag_need), frag_need);
					frag_count = 0;
				end else begin
					frag[frag_count] = b;
					frag_count = n;
				end
			end else begin
				// a sequence cut off by the end is read again, short leads as single bytes
				i = 0;
				while (i < n) begin
					need = seq_len(seq[i]);
					if (need == 1 || i + need > n) begin
						accept_point({13'b0, seq[i]}, 1);
						i++;
					end else begin
						accept_point(join_seq(seq, i, need), need);
						i += need;
					end
				end
				release_held(1'b0);
				if (step_out.size() == 0) begin
					step_out.push_back('{data: 8'h00, last: 1'b1, nob: 1'b1});
					end_markers++;
				end else begin
					t = step_out.pop_back();
					t.last = 1'b1;
					step_out.push_back(t);
				end
				strings_done++;
				clear();
			end
			foreach (step_out[k]) due_bytes.push_back(step_out[k]);
		endfunction

		function void match_output(logic [7:0] b, logic l, logic nob);
			out_item_t want;
			bit        bad;
			checked++;
			if (due_bytes.size() == 0) begin
				fails++;
				if (fails <= REPORT_MAX)
					$display("%0t: item with none due: out_byte %02h out_last %0b no_byte %0b",
						$time, b, l, nob);
				return;
			end
			want = due_bytes.pop_front();
			// out_byte carries nothing on an end-only item
			bad = (l !== want.last) || (nob !== want.nob) || (!want.nob && b !== want.data);
			if (bad) begin
				fails++;
				if (fails <= REPORT_MAX)
					$display("%0t: expected byte %02h last %0b no_byte %0b, got byte %02h last %0b no_byte %0b",
						$time, want.data, want.last, want.nob, b, l, nob);
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic [7:0] in_byte = 8'h00;
	logic       in_last = 1'b0;
	logic       out_ready = 1'b0;
	logic       in_ready;
	logic       out_valid;
	logic [7:0] out_byte;
	logic       out_last;
	logic       no_byte;

	rewrite_checker sb;
	logic [7:0]     str_q[$];
	int             send_idle_pct = 16;
	int             recv_idle_pct = 75;
	int             hold_off = 0;
	int             items_sent = 0;
	int             stall_cycles = 0;

	thai_tone_mark_utf8_rewriter dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte (out_byte),
		.out_last (out_last),
		.no_byte  (no_byte)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// receiver side, with a long hold-off when asked
	initial begin
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				out_ready <= 1'b0;
				hold_off--;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.match_output(out_byte, out_last, no_byte);
	end

	initial begin
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
			end
		end
		$display("thai_tone_mark_utf8_rewriter verification failed");
		$finish;
	end

	task automatic send_item(input logic [7:0] b, input logic l);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		in_last <= l;
		do @(posedge clk); while (!in_ready);
		sb.take_source_byte(b, l);
		items_sent++;
	endtask

	task automatic send_string();
		foreach (str_q[k]) send_item(str_q[k], k == str_q.size() - 1);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.due_bytes.size() != 0) @(posedge clk);
	endtask

	function automatic void put_point(logic [20:0] cp, int len);
		case (len)
			1: str_q.push_back(cp[7:0]);
			2: begin
				str_q.push_back({3'b110, cp[10:6]});
				str_q.push_back({2'b10, cp[5:0]});
			end
			3: begin
				str_q.push_back({4'b1110, cp[15:12]});
				str_q.push_back({2'b10, cp[11:6]});
				str_q.push_back({2'b10, cp[5:0]});
			end
			default: begin
				str_q.push_back({5'b11110, cp[20:18]});
				str_q.push_back({2'b10, cp[17:12]});
				str_q.push_back({2'b10, cp[11:6]});
				str_q.push_back({2'b10, cp[5:0]});
			end
		endcase
	endfunction

	// mostly thai text with tone marks, vowels and sara am, plus some noise
	function automatic void build_string();
		logic [20:0] cp;
		int          points;
		int          sel;
		int          len;
		int          last_len;
		str_q.delete();
		points = ($urandom_range(9) == 0) ? int'($urandom_range(24, 10)) :
			int'($urandom_range(8, 1));
		last_len = 1;
		for (int p = 0; p < points; p++) begin
			sel = $urandom_range(99);
			len = 0;
			if (sel < 18) begin
				cp = KO_KAI + 21'($urandom_range(45));
			end else if (sel < 28) begin
				case ($urandom_range(6))
					0: cp = MAI_HAN_AKAT;
					5: cp = MAITAIKHU;
					6: cp = NIKHAHIT;
					default: cp = SARA_I + 21'($urandom_range(3));
				endcase
			end else if (sel < 42) begin
				cp = TONE_LO + 21'($urandom_range(4));
			end else if (sel < 50) begin
				cp = SARA_AM;
			end else if (sel < 58) begin
				cp = THAI_LO + 21'($urandom_range(127));
			end else if (sel < 70) begin
				cp = SPACE + 21'($urandom_range(94));
			end else if (sel < 73) begin
				cp = NEWLINE;
			end else if (sel < 78) begin
				case ($urandom_range(5))
					0: cp = DEGREE;
					1: cp = MIDDLE_DOT;
					2: cp = EN_DASH;
					3: cp = EM_DASH;
					4: cp = ELLIPSIS;
					default: cp = RIGHT_ARROW;
				endcase
			end else if (sel < 81) begin
				cp = RAISED_LO + 21'($urandom_range(4));
			end else if (sel < 85) begin
				cp = 21'($urandom_range(16'hFFFF));
			end else if (sel < 88) begin
				cp = 21'($urandom_range(21'h1FFFFF));
				len = 4;
			end else if (sel < 91) begin
				// overlong forms
				if ($urandom_range(1) == 0) begin
					cp = SARA_AM;
					len = 4;
				end else begin
					cp = SPACE + 21'($urandom_range(94));
					len = $urandom_range(4, 2);
				end
			end else begin
				cp = 21'($urandom_range(255));
				len = 1;
			end
			if (len == 0) len = (cp < 21'h80) ? 1 : (cp < 21'h800) ? 2 : (cp < 21'h10000) ? 3 : 4;
			put_point(cp, len);
			last_len = len;
		end
		if (last_len > 1 && $urandom_range(5) == 0)
			repeat ($urandom_range(last_len - 1, 1)) void'(str_q.pop_back());
		if ($urandom_range(9) == 0) str_q[$urandom_range(str_q.size() - 1)] = 8'($urandom_range(255));
	endfunction

	task automatic run_directed();
		// tone mark after an upper vowel, ending on the top printable ascii
		str_q.delete();
		put_point(MAI_HAN_AKAT, 3);
		put_point(TONE_LO, 3);
		put_point(TILDE, 1);
		send_string();
		// highest tone mark followed by sara am on the final byte
		str_q.delete();
		put_point(TONE_HI, 3);
		put_point(SARA_AM, 3);
		send_string();
		// 4-byte overlong sara am does not raise, stray bytes, zero byte, cut-off tail
		str_q.delete();
		put_point(TONE_LO + 21'd2, 3);
		put_point(SARA_AM, 4);
		str_q.push_back(8'hB0);
		str_q.push_back(8'h00);
		str_q.push_back(8'hFF);
		put_point(THAI_LO, 3);
		void'(str_q.pop_back());
		send_string();
		// lone lead byte as the whole string gives only the end marker
		str_q.delete();
		str_q.push_back(8'hC2);
		send_string();
	endtask

	initial begin
		int target;
		bit pressed;
		sb = new();
		pressed = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		run_directed();
		wait_drained();
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin send_idle_pct = 16; recv_idle_pct = 75; end
				1: begin send_idle_pct = 75; recv_idle_pct = 16; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			target = items_sent + ITEMS_PER_PHASE;
			while (items_sent < target) begin
				// fill the block against a stopped receiver once
				if (phase == 2 && !pressed && items_sent >= target - 120) begin
					hold_off = LONG_HOLD;
					pressed = 1'b1;
				end
				build_string();
				send_string();
				if (phase < 2 && $urandom_range(24) == 0) wait_drained();
			end
			wait_drained();
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("covered %0d strings, %0d source bytes, %0d raised tone marks, %0d end-only items",
			sb.strings_done, items_sent, sb.raised_marks, sb.end_markers);
		$display("checked %0d output items, %0d failures", sb.checked, sb.fails);
		if (sb.fails == 0 && sb.due_bytes.size() == 0) begin
			$display("thai_tone_mark_utf8_rewriter verification clean");
		end else begin
			$display("thai_tone_mark_utf8_rewriter verification failed");
		end
		$finish;
	end

endmodule
